[rtl/dtp_pkg.sv]
// Shared types and constants for the date/time digit pair parser.
// No dependencies; used by dtp_field_unit and datetime_digit_pair_parser.
package dtp_pkg;

  // Field widths of one result transaction
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned YEAR_W   = 7;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned PAIR_W   = 7;

  // ASCII digit bounds
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  // Field limits on a two-digit value
  localparam logic [PAIR_W-1:0] YEAR_MAX   = 7'd99;
  localparam logic [PAIR_W-1:0] MONTH_MAX  = 7'd12;
  localparam logic [PAIR_W-1:0] DAY_MAX    = 7'd31;
  localparam logic [PAIR_W-1:0] HOUR_MAX   = 7'd23;
  localparam logic [PAIR_W-1:0] MINUTE_MAX = 7'd59;
  localparam logic [PAIR_W-1:0] SECOND_MAX = 7'd59;

  // One result transaction
  typedef struct packed {
    logic                complete;
    logic [YEAR_W-1:0]   year_value;
    logic [MONTH_W-1:0]  month_value;
    logic [DAY_W-1:0]    day_value;
    logic [HOUR_W-1:0]   hour_value;
    logic [MINUTE_W-1:0] minute_value;
    logic [SECOND_W-1:0] second_value;
  } result_t;

endpackage

[rtl/dtp_field_unit.sv]
// Digit pairing, field range check and stored date/time fields.
// Depends on dtp_pkg. Updates state on each advance; result_next is the
// transaction that the advancing character produces.
module dtp_field_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [dtp_pkg::CHAR_W-1:0]   char_code,
  output dtp_pkg::result_t             result_next
);

  typedef enum logic [2:0] {
    FLD_YEAR   = 3'd0,
    FLD_MONTH  = 3'd1,
    FLD_DAY    = 3'd2,
    FLD_HOUR   = 3'd3,
    FLD_MINUTE = 3'd4,
    FLD_SECOND = 3'd5
  } field_t;

  field_t                           field_state, field_state_next;
  logic                             have_first_digit, have_first_digit_next;
  logic [dtp_pkg::DIGIT_W-1:0]      first_digit, first_digit_next;
  logic [dtp_pkg::YEAR_W-1:0]       year_reg, year_reg_next;
  logic [dtp_pkg::MONTH_W-1:0]      month_reg, month_reg_next;
  logic [dtp_pkg::DAY_W-1:0]        day_reg, day_reg_next;
  logic [dtp_pkg::HOUR_W-1:0]       hour_reg, hour_reg_next;
  logic [dtp_pkg::MINUTE_W-1:0]     minute_reg, minute_reg_next;
  logic [dtp_pkg::SECOND_W-1:0]     second_reg, second_reg_next;

  logic                             is_digit;
  logic [dtp_pkg::DIGIT_W-1:0]      digit;
  logic [dtp_pkg::PAIR_W-1:0]       pair_value;
  logic                             pair_done;
  logic                             done;

  // Digit decode; pair value = first*10 + second as shifts and adds
  // ASCII '0'..'9' carry the digit value in the low nibble
  always_comb begin
    is_digit   = (char_code >= dtp_pkg::CHAR_ZERO) && (char_code <= dtp_pkg::CHAR_NINE);
    digit      = char_code[dtp_pkg::DIGIT_W-1:0];
    pair_value = {first_digit, 3'b000} + {2'b00, first_digit, 1'b0}
               + {3'b000, digit};
    pair_done  = is_digit && have_first_digit;
  end

  // Next state of the pair collector and the field sequencer
  always_comb begin
    field_state_next      = field_state;
    have_first_digit_next = have_first_digit;
    first_digit_next      = first_digit;
    year_reg_next         = year_reg;
    month_reg_next        = month_reg;
    day_reg_next          = day_reg;
    hour_reg_next         = hour_reg;
    minute_reg_next       = minute_reg;
    second_reg_next       = second_reg;
    done                  = 1'b0;

    if (!is_digit) begin
      have_first_digit_next = 1'b0;
    end else if (!have_first_digit) begin
      have_first_digit_next = 1'b1;
      first_digit_next      = digit;
    end else begin
      have_first_digit_next = 1'b0;
      field_state_next      = FLD_YEAR;  // out of range falls back to year
      case (field_state)
        FLD_YEAR: begin
          if (pair_value <= dtp_pkg::YEAR_MAX) begin
            year_reg_next    = pair_value;
            field_state_next = FLD_MONTH;
          end
        end
        FLD_MONTH: begin
          if (pair_value != '0 && pair_value <= dtp_pkg::MONTH_MAX) begin
            month_reg_next   = pair_value[dtp_pkg::MONTH_W-1:0];
            field_state_next = FLD_DAY;
          end
        end
        FLD_DAY: begin
          if (pair_value != '0 && pair_value <= dtp_pkg::DAY_MAX) begin
            day_reg_next     = pair_value[dtp_pkg::DAY_W-1:0];
            field_state_next = FLD_HOUR;
          end
        end
        FLD_HOUR: begin
          if (pair_value <= dtp_pkg::HOUR_MAX) begin
            hour_reg_next    = pair_value[dtp_pkg::HOUR_W-1:0];
            field_state_next = FLD_MINUTE;
          end
        end
        FLD_MINUTE: begin
          if (pair_value <= dtp_pkg::MINUTE_MAX) begin
            minute_reg_next  = pair_value[dtp_pkg::MINUTE_W-1:0];
            field_state_next = FLD_SECOND;
          end
        end
        FLD_SECOND: begin
          if (pair_value <= dtp_pkg::SECOND_MAX) begin
            second_reg_next = pair_value[dtp_pkg::SECOND_W-1:0];
            done            = 1'b1;
          end
        end
        default: begin
          field_state_next = FLD_YEAR;
        end
      endcase
    end
  end

  // Transaction carries the stored values after this character
  always_comb begin
    result_next.complete     = pair_done && done;
    result_next.year_value   = year_reg_next;
    result_next.month_value  = month_reg_next;
    result_next.day_value    = day_reg_next;
    result_next.hour_value   = hour_reg_next;
    result_next.minute_value = minute_reg_next;
    result_next.second_value = second_reg_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      field_state      <= FLD_YEAR;
      have_first_digit <= 1'b0;
      first_digit      <= '0;
      year_reg         <= '0;
      month_reg        <= '0;
      day_reg          <= '0;
      hour_reg         <= '0;
      minute_reg       <= '0;
      second_reg       <= '0;
    end else if (advance) begin
      field_state      <= field_state_next;
      have_first_digit <= have_first_digit_next;
      first_digit      <= first_digit_next;
      year_reg         <= year_reg_next;
      month_reg        <= month_reg_next;
      day_reg          <= day_reg_next;
      hour_reg         <= hour_reg_next;
      minute_reg       <= minute_reg_next;
      second_reg       <= second_reg_next;
    end
  end

endmodule

[rtl/datetime_digit_pair_parser.sv]
// Top level of the date/time digit pair parser: input register, field
// unit and result register. Depends on dtp_pkg and dtp_field_unit.
//
// Usage: one ASCII character per input transaction on in_valid/in_stall
// with char_code. Each character yields exactly one result transaction on
// out_valid/out_stall carrying complete and the six stored fields
// (values after that character's update).
// Pipeline: an accepted character is held in the input register and its
// result is presented from the result register (two register stages).
// Throughput: one character per cycle while out_stall holds no result; the
// field check is a single small compare-and-update between the two registers.
// Stall: when out_stall holds a result, the input register keeps its
// character and in_stall rises only if that register is also full, so one
// new character is still taken while a result waits.
// Reset (rst, synchronous): both stages empty, parser expects a year with
// no digit held and all stored fields zero.
module datetime_digit_pair_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dtp_pkg::CHAR_W-1:0]     char_code,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           complete,
  output logic [dtp_pkg::YEAR_W-1:0]     year_value,
  output logic [dtp_pkg::MONTH_W-1:0]    month_value,
  output logic [dtp_pkg::DAY_W-1:0]      day_value,
  output logic [dtp_pkg::HOUR_W-1:0]     hour_value,
  output logic [dtp_pkg::MINUTE_W-1:0]   minute_value,
  output logic [dtp_pkg::SECOND_W-1:0]   second_value
);

  logic                        char_valid;
  logic [dtp_pkg::CHAR_W-1:0]  char_reg;
  logic                        advance;
  logic                        in_accept;
  dtp_pkg::result_t            result_next;
  dtp_pkg::result_t            result_reg;

  // Input register moves on when the result register is free or draining
  assign advance   = char_valid && (!out_valid || !out_stall);
  assign in_stall  = char_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  dtp_field_unit u_field (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .char_code   (char_reg),
    .result_next (result_next)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (in_accept) begin
      char_valid <= 1'b1;
    end else if (advance) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      char_reg <= char_code;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result_next;
    end
  end

  assign complete     = result_reg.complete;
  assign year_value   = result_reg.year_value;
  assign month_value  = result_reg.month_value;
  assign day_value    = result_reg.day_value;
  assign hour_value   = result_reg.hour_value;
  assign minute_value = result_reg.minute_value;
  assign second_value = result_reg.second_value;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for datetime_digit_pair_parser: character stimulus,
// an in-bench field parser predictor and a per-transaction result check.
// Depends on rtl/dtp_pkg.sv and rtl/datetime_digit_pair_parser.sv.
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 200;

  typedef enum logic [2:0] {
    FLD_YEAR, FLD_MONTH, FLD_DAY, FLD_HOUR, FLD_MINUTE, FLD_SECOND
  } field_t;

  typedef logic [dtp_pkg::CHAR_W-1:0]  char_t;
  typedef logic [dtp_pkg::DIGIT_W-1:0] digit_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [dtp_pkg::CHAR_W-1:0]    char_code = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          complete;
  logic [dtp_pkg::YEAR_W-1:0]    year_value;
  logic [dtp_pkg::MONTH_W-1:0]   month_value;
  logic [dtp_pkg::DAY_W-1:0]     day_value;
  logic [dtp_pkg::HOUR_W-1:0]    hour_value;
  logic [dtp_pkg::MINUTE_W-1:0]  minute_value;
  logic [dtp_pkg::SECOND_W-1:0]  second_value;

  datetime_digit_pair_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .complete     (complete),
    .year_value   (year_value),
    .month_value  (month_value),
    .day_value    (day_value),
    .hour_value   (hour_value),
    .minute_value (minute_value),
    .second_value (second_value)
  );

  always #5 clk = ~clk;

  // Idling controls, shared by the sender task and the receiver process
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req_seq = 0;
  int unsigned chars_sent = 0;
  int unsigned error_count = 0;

  // Parser state mirrored by the predictor
  field_t                      exp_field = FLD_YEAR;
  logic                        exp_have_digit = 1'b0;
  logic [dtp_pkg::DIGIT_W-1:0] exp_first_digit = '0;
  dtp_pkg::result_t            exp_stamp = '0;
  dtp_pkg::result_t            pending_results[$];

  function automatic int unsigned field_max(field_t f);
    case (f)
      FLD_YEAR:   return dtp_pkg::YEAR_MAX;
      FLD_MONTH:  return dtp_pkg::MONTH_MAX;
      FLD_DAY:    return dtp_pkg::DAY_MAX;
      FLD_HOUR:   return dtp_pkg::HOUR_MAX;
      FLD_MINUTE: return dtp_pkg::MINUTE_MAX;
      default:    return dtp_pkg::SECOND_MAX;
    endcase
  endfunction

  function automatic int unsigned field_min(field_t f);
    return (f == FLD_MONTH || f == FLD_DAY) ? 1 : 0;
  endfunction

  // Advance the mirrored parser by one character and queue its result
  function automatic void parse_char(logic [dtp_pkg::CHAR_W-1:0] c);
    int unsigned pair;
    field_t      nxt;
    logic        in_rng;
    exp_stamp.complete = 1'b0;
    if (c >= dtp_pkg::CHAR_ZERO && c <= dtp_pkg::CHAR_NINE) begin
      if (exp_have_digit) begin
        exp_have_digit = 1'b0;
        pair = exp_first_digit * 10 + int'(c - dtp_pkg::CHAR_ZERO);
        in_rng = (pair >= field_min(exp_field)) && (pair <= field_max(exp_field));
        nxt = FLD_YEAR;
        if (in_rng) begin
          case (exp_field)
            FLD_YEAR: begin
              exp_stamp.year_value = pair[dtp_pkg::YEAR_W-1:0];
              nxt = FLD_MONTH;
            end
            FLD_MONTH: begin
              exp_stamp.month_value = pair[dtp_pkg::MONTH_W-1:0];
              nxt = FLD_DAY;
            end
            FLD_DAY: begin
              exp_stamp.day_value = pair[dtp_pkg::DAY_W-1:0];
              nxt = FLD_HOUR;
            end
            FLD_HOUR: begin
              exp_stamp.hour_value = pair[dtp_pkg::HOUR_W-1:0];
              nxt = FLD_MINUTE;
            end
            FLD_MINUTE: begin
              exp_stamp.minute_value = pair[dtp_pkg::MINUTE_W-1:0];
              nxt = FLD_SECOND;
            end
            FLD_SECOND: begin
              exp_stamp.second_value = pair[dtp_pkg::SECOND_W-1:0];
              exp_stamp.complete = 1'b1;
            end
            default: ;
          endcase
        end
        exp_field = nxt;
      end else begin
        exp_have_digit = 1'b1;
        exp_first_digit = digit_t'(c - dtp_pkg::CHAR_ZERO);
      end
    end else begin
      exp_have_digit = 1'b0;
    end
    pending_results.push_back(exp_stamp);
  endfunction

  // Send one character; returns once the input transaction is accepted
  task automatic send_char(input logic [dtp_pkg::CHAR_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic send_pair(input int unsigned v);
    send_char(dtp_pkg::CHAR_ZERO + char_t'(v / 10));
    send_char(dtp_pkg::CHAR_ZERO + char_t'(v % 10));
  endtask

  function automatic logic [dtp_pkg::CHAR_W-1:0] pick_non_digit();
    logic [dtp_pkg::CHAR_W-1:0] c;
    do c = char_t'($urandom_range(255));
    while (c >= dtp_pkg::CHAR_ZERO && c <= dtp_pkg::CHAR_NINE);
    return c;
  endfunction

  // Field value, in range or out of range, leaning toward the limits
  function automatic int unsigned pick_value(field_t f, bit good);
    int unsigned lo;
    int unsigned hi;
    lo = field_min(f);
    hi = field_max(f);
    if (good || hi == 99) begin
      case ($urandom_range(9))
        0:       return lo;
        1:       return hi;
        default: return $urandom_range(hi, lo);
      endcase
    end
    if (lo == 1 && $urandom_range(3) == 0) return 0;
    return $urandom_range(99, hi + 1);
  endfunction

  // Well-formed date/time with random content; stops at a bad field
  task automatic send_stamp();
    field_t      f;
    bit          good;
    int unsigned v;
    // bring the parser back to a clean year field first
    if (exp_have_digit) send_char(pick_non_digit());
    if (exp_field != FLD_YEAR) send_pair(99);
    for (int i = 0; i < 6; i++) begin
      f = field_t'(i);
      good = ($urandom_range(99) < 90);
      v = pick_value(f, good);
      if (i > 0 && $urandom_range(99) < 25) send_char(pick_non_digit());
      send_pair(v);
      if (!good && field_max(f) != 99) break;
    end
  endtask

  // Mix of stamps, raw noise and truncated sequences
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned kind;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_stamp();
      end else if (kind < 85) begin
        repeat ($urandom_range(4, 1)) send_char(char_t'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(4, 1)) send_pair($urandom_range(99));
        if ($urandom_range(1)) send_char(dtp_pkg::CHAR_ZERO + char_t'($urandom_range(9)));
        send_char(pick_non_digit());
      end
    end
  endtask

  // Directed: a lone digit dropped by non-digits, byte extremes
  task automatic test_dropped_digit();
    send_char(8'hFF);
    send_char(dtp_pkg::CHAR_ZERO + 8'd5);
    send_char(8'h00);
  endtask

  // Directed: every field at its upper limit, ends complete
  task automatic test_max_stamp();
    send_pair(dtp_pkg::YEAR_MAX);
    send_pair(dtp_pkg::MONTH_MAX);
    send_pair(dtp_pkg::DAY_MAX);
    send_pair(dtp_pkg::HOUR_MAX);
    send_pair(dtp_pkg::MINUTE_MAX);
    send_pair(dtp_pkg::SECOND_MAX);
  endtask

  // Directed: lower limits, then an out-of-range second
  task automatic test_min_stamp_bad_second();
    send_pair(0);
    send_pair(1);
    send_pair(1);
    send_pair(0);
    send_pair(0);
    send_pair(dtp_pkg::SECOND_MAX + 1);
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(220);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 63;
    recv_stall_pct = 0;
    run_random(220);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 63;
    run_random(220);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    run_random(200);
  endtask

  // Long output hold-off while characters keep coming, so input stalls
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req_seq++;
    run_random(40);
  endtask

  task automatic check_field(input string name, input int unsigned expv,
                             input int unsigned gotv);
    if (expv != gotv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, gotv);
      error_count++;
    end
  endtask

  // Result check and receiver stall generation
  int unsigned hold_seen_seq = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    dtp_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction, actual complete %0b year %0d",
                   $time, complete, year_value);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("complete", want.complete, complete);
          check_field("year_value", want.year_value, year_value);
          check_field("month_value", want.month_value, month_value);
          check_field("day_value", want.day_value, day_value);
          check_field("hour_value", want.hour_value, hour_value);
          check_field("minute_value", want.minute_value, minute_value);
          check_field("second_value", want.second_value, second_value);
        end
      end
      if (hold_seen_seq != hold_req_seq) begin
        hold_seen_seq = hold_req_seq;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_dropped_digit();
    test_max_stamp();
    test_min_stamp_bad_second();
    test_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_output_backpressure();

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
